// ----- sv/sme_pkg.sv -----
// shared types and constants for the stack machine execute block
package sme_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [2:0] CMD_LDWS  = 3'd0;
  localparam logic [2:0] CMD_SBN   = 3'd1;
  localparam logic [2:0] CMD_STWS  = 3'd2;
  localparam logic [2:0] CMD_LIX   = 3'd3;
  localparam logic [2:0] CMD_REG   = 3'd4;
  localparam logic [2:0] CMD_HWR   = 3'd5;
  localparam logic [2:0] CMD_HRD   = 3'd6;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_OVF   = 3'd1;
  localparam logic [2:0] ERR_UNF   = 3'd2;
  localparam logic [2:0] ERR_ILREG = 3'd3;
  localparam logic [2:0] ERR_UNIMP = 3'd4;
  localparam logic [2:0] ERR_BADOP = 3'd5;

  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_SHL  = 4'd3;
  localparam logic [3:0] OP_SHR  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd5;
  localparam logic [3:0] OP_AND  = 4'd6;
  localparam logic [3:0] OP_MOVE = 4'd8;
  localparam logic [3:0] OP_XCHG = 4'd9;

  localparam logic [1:0] R_X = 2'd0;
  localparam logic [1:0] R_Y = 2'd1;
  localparam logic [1:0] R_Z = 2'd2;
  localparam logic [1:0] R_T = 2'd3;

  localparam logic [11:0] DIRECT_BASE = 12'h100;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] operand;
    logic [11:0] host_address;
    logic        mode;
    logic [3:0]  alu_op;
    logic [1:0]  from_reg;
    logic [1:0]  to_reg;
  } sme_in_t;

  typedef struct packed {
    logic [11:0] x_value;
    logic [11:0] y_value;
    logic [3:0]  z_value;
    logic [3:0]  t_value;
    logic [11:0] read_data;
    logic [2:0]  error_code;
  } sme_out_t;

  // address select for the memory port
  typedef enum logic [2:0] {
    AS_Z    = 3'd0,
    AS_HOST = 3'd1,
    AS_DISP = 3'd2,
    AS_ZERO = 3'd3,
    AS_IDX  = 3'd4
  } asel_t;

  // write data select
  typedef enum logic [1:0] {
    WS_Y   = 2'd0,
    WS_X   = 2'd1,
    WS_OPD = 2'd2,
    WS_ADD = 2'd3
  } wsel_t;

  typedef struct packed {
    logic    load;     // capture item
    logic    mem_en;
    logic    mem_we;
    asel_t   asel;
    wsel_t   wsel;
    logic    cap;      // capture read data into t2
    logic    commit;   // update architectural regs
    logic    out_load;
  } sme_cmd_t;

  typedef struct packed {
    sme_in_t item;
    logic    err;      // item causes an error
    logic    y_lt_x;
  } sme_sts_t;

  // fold a 12-bit address into the memory by repeated compare and subtract
  function automatic logic [AW-1:0] addr_of(input logic [11:0] a);
    logic [12:0] r;
    r = {1'b0, a};
    for (int k = 0; k < 8; k++)
      if (r >= 13'(MEM_WORDS)) r = r - 13'(MEM_WORDS);
    return r[AW-1:0];
  endfunction

endpackage

// ----- sv/sme_if.sv -----
// valid/ready channel interfaces
interface sme_in_if import sme_pkg::*; (input logic clk);
  logic    valid;
  logic    ready;
  sme_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sme_out_if import sme_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  sme_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sme_datapath.sv -----
// registers, word memory and result register of the stack machine
module sme_datapath import sme_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  sme_in_t  in_item,
  input  sme_cmd_t cmd,
  output sme_sts_t sts,
  output sme_out_t out_data
);

  logic [11:0] mem [MEM_WORDS];
  logic [11:0] rd_r;
  sme_in_t     it_r;
  logic [11:0] x_r, y_r, x_nxt, y_nxt;
  logic [3:0]  z_r, t_r, z_nxt, t_nxt;
  logic [11:0] t2_r;
  logic [11:0] addr;
  logic [11:0] wdata;
  logic [11:0] hread_nxt;
  logic [2:0]  err;
  sme_out_t    out_r;

  function automatic logic [11:0] rget(input logic [1:0] i, input logic [11:0] x,
                                       input logic [11:0] y, input logic [3:0] z,
                                       input logic [3:0] t);
    logic [11:0] v;
    case (i)
      R_X:     v = x;
      R_Y:     v = y;
      R_Z:     v = {8'd0, z};
      default: v = {8'd0, t};
    endcase
    return v;
  endfunction

  function automatic logic [11:0] alu(input logic [3:0] op, input logic [11:0] a,
                                      input logic [11:0] b);
    logic [11:0] v;
    case (op)
      OP_ADD:  v = a + b;
      OP_SUB:  v = a - b;
      OP_SHL:  v = (b >= 12'd12) ? 12'd0 : a << b[3:0];
      OP_SHR:  v = (b >= 12'd12) ? 12'd0 : a >> b[3:0];
      OP_OR:   v = a | b;
      OP_AND:  v = a & b;
      default: v = a ^ b;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_item;
    if (cmd.cap) t2_r <= rd_r;
  end

  always_comb begin
    case (cmd.asel)
      AS_Z:    addr = {8'd0, z_r};
      AS_HOST: addr = it_r.host_address;
      AS_DISP: addr = it_r.mode ? it_r.operand + DIRECT_BASE : it_r.operand + t2_r;
      AS_ZERO: addr = 12'd0;
      default: addr = it_r.mode ? it_r.operand + DIRECT_BASE : it_r.operand + y_r;
    endcase
    case (cmd.wsel)
      // register move source: memory at Z was read into rd_r beforehand
      WS_Y:    wdata = (it_r.command != CMD_REG) ? y_r
                       : (it_r.from_reg == R_Z && it_r.mode) ? rd_r
                       : rget(it_r.from_reg, x_r, y_r, z_r, t_r);
      WS_X:    wdata = x_r;
      WS_OPD:  wdata = it_r.operand;
      default: wdata = rd_r + it_r.operand;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_en) begin
      if (cmd.mem_we) mem[addr_of(addr)] <= wdata;
      else rd_r <= mem[addr_of(addr)];
    end
  end

  // error decode
  always_comb begin
    err = ERR_OK;
    case (it_r.command)
      CMD_LDWS: if (z_r == 4'd0) err = ERR_OVF;
      CMD_STWS: if (z_r == 4'hf) err = ERR_UNF;
      CMD_LIX:  if (it_r.mode && z_r == 4'd0) err = ERR_UNF;
      CMD_REG: begin
        if (!it_r.alu_op[3]) begin
          if (it_r.from_reg[1] || it_r.to_reg[1]) err = ERR_ILREG;
          else if (it_r.alu_op == 4'd0) err = ERR_BADOP;
        end else if (it_r.alu_op != OP_MOVE && it_r.alu_op != OP_XCHG) begin
          err = ERR_UNIMP;
        end
      end
      CMD_SBN, CMD_HWR, CMD_HRD: err = ERR_OK;
      default: err = ERR_BADOP;
    endcase
  end

  assign sts.item   = it_r;
  assign sts.err    = (err != ERR_OK);
  assign sts.y_lt_x = (y_r < x_r);

  // architectural update; rd_r holds the last memory read
  always_comb begin
    logic [11:0] src, old;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; t_nxt = t_r;
    hread_nxt = 12'd0;
    src = 12'd0; old = 12'd0;
    if (err == ERR_OK) begin
      case (it_r.command)
        CMD_LDWS: begin
          z_nxt = z_r - 4'd1; y_nxt = x_r; x_nxt = rd_r;
        end
        CMD_SBN: begin
          x_nxt = y_r - x_r; y_nxt = {8'd0, z_r}; z_nxt = t_r;
        end
        CMD_STWS: begin
          x_nxt = y_r; y_nxt = rd_r; z_nxt = z_r + 4'd1;
        end
        CMD_LIX: begin
          if (it_r.mode) z_nxt = z_r - 4'd1;
          else begin
            t_nxt = z_r; z_nxt = y_r[3:0];
          end
          y_nxt = x_r; x_nxt = it_r.operand;
        end
        CMD_REG: begin
          if (!it_r.alu_op[3]) begin
            if (it_r.from_reg == R_Y) x_nxt = alu(it_r.alu_op, x_r, y_r);
            else x_nxt = alu(it_r.alu_op, y_r, x_r);
          end else begin
            src = (it_r.from_reg == R_Z && it_r.mode) ? rd_r
                  : rget(it_r.from_reg, x_r, y_r, z_r, t_r);
            if (it_r.alu_op == OP_MOVE) begin
              if (!(it_r.to_reg == R_Z && it_r.mode)) begin
                case (it_r.to_reg)
                  R_X: x_nxt = src;
                  R_Y: y_nxt = src;
                  R_Z: z_nxt = src[3:0];
                  default: t_nxt = src[3:0];
                endcase
              end
            end else begin
              old = rget(it_r.to_reg, x_r, y_r, z_r, t_r);
              if (it_r.to_reg[1] || it_r.from_reg[1]) old = {8'd0, old[3:0]};
              case (it_r.from_reg)
                R_X: x_nxt = old;
                R_Y: y_nxt = old;
                R_Z: z_nxt = old[3:0];
                default: t_nxt = old[3:0];
              endcase
              case (it_r.to_reg)
                R_X: x_nxt = src;
                R_Y: y_nxt = src;
                R_Z: z_nxt = src[3:0];
                default: t_nxt = src[3:0];
              endcase
            end
          end
        end
        CMD_HRD: hread_nxt = rd_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0; y_r <= '0; z_r <= '0; t_r <= '0;
    end else if (cmd.commit) begin
      x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; t_r <= t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.x_value    <= x_nxt;
      out_r.y_value    <= y_nxt;
      out_r.z_value    <= z_nxt;
      out_r.t_value    <= t_nxt;
      out_r.read_data  <= hread_nxt;
      out_r.error_code <= err;
    end
  end

  assign out_data = out_r;

endmodule

// ----- sv/sme_ctrl.sv -----
// sequencer for memory accesses of one instruction
module sme_ctrl import sme_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  sme_sts_t sts,
  output sme_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_A1   = 6'b000010,
    S_A2   = 6'b000100,
    S_A3   = 6'b001000,
    S_WAIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t st_r, st_nxt;
  logic   ov_r, ov_nxt;
  logic   fin;
  sme_in_t it;

  assign it = sts.item;
  assign in_ready = (st_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    cmd.asel = AS_Z;
    cmd.wsel = WS_Y;
    st_nxt = st_r;
    fin = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1; st_nxt = S_A1;
        end
      end
      S_A1: begin
        // first access
        st_nxt = S_A2;
        if (!sts.err) begin
          case (it.command)
            CMD_LDWS, CMD_STWS: begin
              cmd.mem_en = 1'b1;
              cmd.asel = (it.command == CMD_LDWS) ? AS_Z : AS_IDX;
              cmd.mem_we = (it.command == CMD_STWS);
              cmd.wsel = WS_X;
            end
            CMD_SBN: begin
              cmd.mem_en = 1'b1; cmd.asel = AS_ZERO;
            end
            CMD_LIX: begin
              cmd.mem_en = it.mode; cmd.mem_we = 1'b1; cmd.asel = AS_Z;
            end
            CMD_REG: begin
              if (it.alu_op == OP_MOVE || it.alu_op == OP_XCHG) begin
                cmd.mem_en = (it.from_reg == R_Z) && it.mode;
                cmd.asel = AS_Z;
              end
            end
            CMD_HWR: begin
              cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
              cmd.asel = AS_HOST; cmd.wsel = WS_OPD;
            end
            CMD_HRD: begin
              cmd.mem_en = 1'b1; cmd.asel = AS_HOST;
            end
            default: ;
          endcase
        end
      end
      S_A2: begin
        st_nxt = S_A3;
        if (!sts.err) begin
          case (it.command)
            CMD_LDWS: begin
              cmd.cap = 1'b1;
              cmd.mem_en = 1'b1; cmd.mem_we = 1'b1; cmd.asel = AS_Z;
            end
            CMD_STWS: begin
              cmd.mem_en = 1'b1; cmd.asel = AS_Z;
            end
            CMD_SBN: begin
              cmd.mem_en = sts.y_lt_x; cmd.mem_we = 1'b1;
              cmd.asel = AS_ZERO; cmd.wsel = WS_ADD;
            end
            CMD_REG: begin
              // move to memory at Z
              cmd.mem_en = (it.alu_op == OP_MOVE) && (it.to_reg == R_Z) && it.mode;
              cmd.mem_we = 1'b1; cmd.asel = AS_Z;
            end
            default: ;
          endcase
        end
      end
      S_A3: begin
        st_nxt = S_WAIT;
        if (!sts.err && it.command == CMD_LDWS) begin
          cmd.mem_en = 1'b1; cmd.asel = AS_DISP;
        end
      end
      S_WAIT: st_nxt = S_DONE;
      S_DONE: begin
        cmd.commit = 1'b1; cmd.out_load = 1'b1; fin = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_ready) ov_nxt = 1'b0;
    if (fin) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end

endmodule

// ----- sv/stack_machine_execute_top.sv -----
// top level of the stack machine execute block
// each item passes through the accept step, three access steps on the
// single-port word memory, one wait step and the commit step; no new item is
// accepted until the last has committed and its result is taken or being taken
// reset: synchronous active-low rst_n clears X, Y, Z, T and the handshake state;
// the word memory is not cleared and holds garbage until written
module stack_machine_execute_top import sme_pkg::*; (
  input logic clk,
  input logic rst_n,
  sme_in_if.sink    in_ch,
  sme_out_if.source out_ch
);

  sme_cmd_t cmd;
  sme_sts_t sts;

  // sequencer: one access per step
  sme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, memory and result item register
  sme_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_ch.data)
  );

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the stack machine execute block
`timescale 1ns / 100ps

module tb_top;
  import sme_pkg::*;

  // codes the package does not name
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_UNIMP_LO = 4'd10;
  localparam logic [2:0] CMD_BAD = 3'd7;

  logic clk;
  logic rst_n;

  sme_in_if  in_ch (clk);
  sme_out_if out_ch (clk);

  stack_machine_execute_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // machine state as the predictor sees it
  logic [11:0] m_x, m_y;
  logic [3:0]  m_z, m_t;
  logic [11:0] m_mem [MEM_WORDS];
  bit          m_wr [MEM_WORDS];

  sme_out_t expected_q [$];
  int fail_count;
  int item_count;
  int result_count;
  int err_seen [8];
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_left;

  function automatic int waddr(input logic [11:0] a);
    return int'(a) % MEM_WORDS;
  endfunction

  // memory write that also marks the word as written
  task automatic mem_put(input logic [11:0] a, input logic [11:0] v);
    m_mem[waddr(a)] = v;
    m_wr[waddr(a)] = 1'b1;
  endtask

  function automatic logic [11:0] reg_val(input logic [1:0] r);
    case (r)
      R_X: return m_x;
      R_Y: return m_y;
      R_Z: return {8'd0, m_z};
      default: return {8'd0, m_t};
    endcase
  endfunction

  task automatic reg_put(input logic [1:0] r, input logic [11:0] v);
    case (r)
      R_X: m_x = v;
      R_Y: m_y = v;
      R_Z: m_z = v[3:0];
      default: m_t = v[3:0];
    endcase
  endtask

  function automatic logic [11:0] alu_result(input logic [3:0] op, input logic [11:0] a,
                                             input logic [11:0] b);
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_SHL: return (b >= 12) ? 12'd0 : a << b;
      OP_SHR: return (b >= 12) ? 12'd0 : a >> b;
      OP_OR:  return a | b;
      OP_AND: return a & b;
      default: return a ^ b;
    endcase
  endfunction

  // advance the machine by one item and return the expected result
  task automatic execute_item(input sme_in_t it, output sme_out_t r);
    logic [11:0] t2, src, old;
    logic [2:0]  err;
    logic [11:0] rdata;
    err = ERR_OK;
    rdata = '0;
    case (it.command)
      CMD_LDWS: begin
        if (m_z == 4'd0) err = ERR_OVF;
        else begin
          t2 = m_mem[waddr({8'd0, m_z})];
          mem_put({8'd0, m_z}, m_y);
          m_z = m_z - 4'd1;
          m_y = m_x;
          // load comes after the push write
          m_x = it.mode ? m_mem[waddr(it.operand + DIRECT_BASE)]
                        : m_mem[waddr(it.operand + t2)];
        end
      end
      CMD_SBN: begin
        if (m_y < m_x) mem_put(12'd0, m_mem[0] + it.operand);
        m_x = m_y - m_x;
        m_y = {8'd0, m_z};
        m_z = m_t;
      end
      CMD_STWS: begin
        if (m_z == 4'd15) err = ERR_UNF;
        else begin
          if (it.mode) mem_put(it.operand + DIRECT_BASE, m_x);
          else mem_put(it.operand + m_y, m_x);
          m_x = m_y;
          m_y = m_mem[waddr({8'd0, m_z})];
          m_z = m_z + 4'd1;
        end
      end
      CMD_LIX: begin
        if (it.mode && m_z == 4'd0) err = ERR_UNF;
        else begin
          if (it.mode) begin
            mem_put({8'd0, m_z}, m_y);
            m_z = m_z - 4'd1;
          end else begin
            m_t = m_z;
            m_z = m_y[3:0];
          end
          m_y = m_x;
          m_x = it.operand;
        end
      end
      CMD_REG: begin
        if (!it.alu_op[3]) begin
          if (it.from_reg >= R_Z || it.to_reg >= R_Z) err = ERR_ILREG;
          else if (it.alu_op == OP_NONE) err = ERR_BADOP;
          else if (it.from_reg == R_Y) m_x = alu_result(it.alu_op, m_x, m_y);
          else m_x = alu_result(it.alu_op, m_y, m_x);
        end else if (it.alu_op >= OP_UNIMP_LO) err = ERR_UNIMP;
        else begin
          if (it.from_reg == R_Z && it.mode) src = m_mem[waddr({8'd0, m_z})];
          else src = reg_val(it.from_reg);
          if (it.alu_op == OP_MOVE) begin
            if (it.to_reg == R_Z && it.mode) mem_put({8'd0, m_z}, src);
            else reg_put(it.to_reg, src);
          end else begin
            old = reg_val(it.to_reg);
            if (it.to_reg >= R_Z || it.from_reg >= R_Z) old = old & 12'h00f;
            reg_put(it.from_reg, old);
            reg_put(it.to_reg, src);
          end
        end
      end
      CMD_HWR: mem_put(it.host_address, it.operand);
      CMD_HRD: rdata = m_mem[waddr(it.host_address)];
      default: err = ERR_BADOP;
    endcase
    r.x_value = m_x;
    r.y_value = m_y;
    r.z_value = m_z;
    r.t_value = m_t;
    r.read_data = rdata;
    r.error_code = err;
  endtask

  // first memory word the item would read before it was ever written, or -1
  function automatic int unread_addr(input sme_in_t it);
    int a0, a1;
    a0 = waddr({8'd0, m_z});
    case (it.command)
      CMD_LDWS: begin
        if (m_z == 4'd0) return -1;
        if (!m_wr[a0]) return a0;
        a1 = it.mode ? waddr(it.operand + DIRECT_BASE) : waddr(it.operand + m_mem[a0]);
        if (a1 != a0 && !m_wr[a1]) return a1;
      end
      CMD_SBN: if (m_y < m_x && !m_wr[0]) return 0;
      CMD_STWS: begin
        if (m_z == 4'd15) return -1;
        a1 = it.mode ? waddr(it.operand + DIRECT_BASE) : waddr(it.operand + m_y);
        if (a1 != a0 && !m_wr[a0]) return a0;
      end
      CMD_REG: begin
        if ((it.alu_op == OP_MOVE || it.alu_op == OP_XCHG) && it.from_reg == R_Z
            && it.mode && !m_wr[a0]) return a0;
      end
      CMD_HRD: if (!m_wr[waddr(it.host_address)]) return waddr(it.host_address);
      default: ;
    endcase
    return -1;
  endfunction

  function automatic sme_in_t make_item(input logic [2:0] cmd, input logic [11:0] opd,
                                        input logic [11:0] haddr, input logic mode,
                                        input logic [3:0] aop, input logic [1:0] from_r,
                                        input logic [1:0] to_r);
    sme_in_t it;
    it.command = cmd;
    it.operand = opd;
    it.host_address = haddr;
    it.mode = mode;
    it.alu_op = aop;
    it.from_reg = from_r;
    it.to_reg = to_r;
    return it;
  endfunction

  // offer one item, optionally after an idle gap, and predict it on accept
  task automatic offer_item(input sme_in_t it);
    sme_out_t r;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    execute_item(it, r);
    expected_q.push_back(r);
    item_count++;
  endtask

  // host-write every word the item would read unwritten, then send it
  task automatic send_item(input sme_in_t it);
    int a;
    a = unread_addr(it);
    while (a >= 0) begin
      offer_item(make_item(CMD_HWR, 12'($urandom), 12'(a), 1'b0, OP_NONE, R_X, R_X));
      a = unread_addr(it);
    end
    offer_item(it);
  endtask

  // wait until every expected result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    sme_out_t e;
    sme_out_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", a);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        result_count++;
        err_seen[e.error_code]++;
        if (a.x_value !== e.x_value) begin
          $error("x_value expected %h got %h", e.x_value, a.x_value);
          fail_count++;
        end
        if (a.y_value !== e.y_value) begin
          $error("y_value expected %h got %h", e.y_value, a.y_value);
          fail_count++;
        end
        if (a.z_value !== e.z_value) begin
          $error("z_value expected %h got %h", e.z_value, a.z_value);
          fail_count++;
        end
        if (a.t_value !== e.t_value) begin
          $error("t_value expected %h got %h", e.t_value, a.t_value);
          fail_count++;
        end
        if (a.read_data !== e.read_data) begin
          $error("read_data expected %h got %h", e.read_data, a.read_data);
          fail_count++;
        end
        if (a.error_code !== e.error_code) begin
          $error("error_code expected %0d got %0d", e.error_code, a.error_code);
          fail_count++;
        end
      end
    end
  end

  // directed: field extremes, every operation and every error
  task automatic test_directed();
    send_item(make_item(CMD_LDWS, 12'h000, 12'h000, 1'b1, OP_NONE, R_X, R_X)); // overflow at z 0
    send_item(make_item(CMD_LIX, 12'h123, 12'h000, 1'b1, OP_NONE, R_X, R_X));  // underflow at z 0
    send_item(make_item(CMD_LIX, 12'hfff, 12'hfff, 1'b0, 4'hf, R_T, R_T));      // pointer swap
    send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b0, OP_MOVE, R_X, R_Z));   // z = 15
    send_item(make_item(CMD_STWS, 12'h000, 12'h000, 1'b1, OP_NONE, R_X, R_X));  // underflow at z 15
    send_item(make_item(CMD_LDWS, 12'hfff, 12'h000, 1'b1, OP_NONE, R_X, R_X));  // direct, wraps
    send_item(make_item(CMD_LDWS, 12'h7a5, 12'h000, 1'b0, OP_NONE, R_X, R_X));  // indexed
    send_item(make_item(CMD_LIX, 12'h800, 12'h000, 1'b1, OP_NONE, R_X, R_X));   // push mode
    send_item(make_item(CMD_STWS, 12'h0ff, 12'h000, 1'b1, OP_NONE, R_X, R_X));
    send_item(make_item(CMD_STWS, 12'hf00, 12'h000, 1'b0, OP_NONE, R_X, R_X));
    send_item(make_item(CMD_LIX, 12'h001, 12'h000, 1'b0, OP_NONE, R_X, R_X));
    send_item(make_item(CMD_SBN, 12'hfff, 12'h000, 1'b0, OP_NONE, R_X, R_X));
    send_item(make_item(CMD_SBN, 12'h555, 12'h000, 1'b1, OP_NONE, R_X, R_X));
    for (int op = 1; op <= 7; op++)
      send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b0, 4'(op), (op % 2) ? R_Y : R_X, R_X));
    send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b0, OP_NONE, R_X, R_Y));   // bad alu code
    send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b0, OP_ADD, R_T, R_X));    // illegal register
    send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b1, 4'hf, R_X, R_X));      // unimplemented
    send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b1, OP_XCHG, R_Z, R_Y));   // from memory at z
    send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b1, OP_MOVE, R_Y, R_Z));   // into memory at z
    send_item(make_item(CMD_REG, 12'h000, 12'h000, 1'b1, OP_MOVE, R_Z, R_Z));   // memory to itself
    send_item(make_item(CMD_BAD, 12'hfff, 12'hfff, 1'b1, 4'hf, R_T, R_T));      // unused command
    send_item(make_item(CMD_HRD, 12'h000, 12'hfff, 1'b0, OP_NONE, R_X, R_X));
    wait_drained();
  endtask

  // random items, weighted toward real instructions
  task automatic test_random(input int count);
    sme_in_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      it = sme_in_t'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 14) it.command = CMD_LDWS;
      else if (pick < 26) it.command = CMD_SBN;
      else if (pick < 40) it.command = CMD_STWS;
      else if (pick < 54) it.command = CMD_LIX;
      else if (pick < 82) it.command = CMD_REG;
      else if (pick < 89) it.command = CMD_HWR;
      else if (pick < 97) it.command = CMD_HRD;
      else it.command = CMD_BAD;
      // keep most register ops on legal codes
      if (it.command == CMD_REG && $urandom_range(3) != 0)
        it.alu_op = 4'($urandom_range(1, 9));
      if (it.command == CMD_REG && it.alu_op < OP_MOVE && $urandom_range(2) != 0) begin
        it.from_reg[1] = 1'b0;
        it.to_reg[1] = 1'b0;
      end
      send_item(it);
    end
  endtask

  // receiver holds off while the sender keeps offering, then the results drain
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    test_random(40);
    wait_drained();
  endtask

  // stimulus
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    fail_count = 0;
    item_count = 0;
    result_count = 0;
    hold_left = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (err_seen[i]) err_seen[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();

    // idling phases: none, sender idle, receiver stall, both
    sender_idle_pct = 0;  recv_stall_pct = 0;  test_random(180);
    sender_idle_pct = 53; recv_stall_pct = 0;  test_random(180);
    sender_idle_pct = 0;  recv_stall_pct = 53; test_random(180);
    sender_idle_pct = 20; recv_stall_pct = 20; test_random(180);
    wait_drained();
    test_backpressure();

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d items, %0d results checked, memory words written on first use",
             item_count, result_count);
    $display("results by code: ok %0d ovf %0d unf %0d ilreg %0d unimp %0d badop %0d",
             err_seen[ERR_OK], err_seen[ERR_OVF], err_seen[ERR_UNF],
             err_seen[ERR_ILREG], err_seen[ERR_UNIMP], err_seen[ERR_BADOP]);
    if (fail_count == 0) begin
      $display("stack_machine_execute_top verification clean");
    end else begin
      $display("stack_machine_execute_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("stack_machine_execute_top verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/sme_pkg.sv
sv/sme_if.sv
sv/sme_datapath.sv
sv/sme_ctrl.sv
sv/stack_machine_execute_top.sv
dv/tb_top.sv
